FILE: hw/rtl/cafu_pkg.sv
// ============================================================================
// cafu_pkg
// Shared types and constants for the CPU ALU and flag unit.
// ============================================================================
package cafu_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_ADC      = 5'd1,
        OP_SUB      = 5'd2,
        OP_SBC      = 5'd3,
        OP_AND      = 5'd4,
        OP_XOR      = 5'd5,
        OP_OR       = 5'd6,
        OP_CP       = 5'd7,
        OP_INC      = 5'd8,
        OP_DEC      = 5'd9,
        OP_RLCA     = 5'd10,
        OP_RRCA     = 5'd11,
        OP_RLA      = 5'd12,
        OP_DAA      = 5'd13,
        OP_CPL      = 5'd14,
        OP_SCF      = 5'd15,
        OP_CCF      = 5'd16,
        OP_ADD16    = 5'd17,
        OP_SPOFFSET = 5'd18
    } alu_op_t;

    // DAA correction constants
    localparam logic [7:0] DAA_LO_CORR  = 8'h06;
    localparam logic [7:0] DAA_HI_CORR  = 8'h60;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    // Flag group
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } alu_flags_t;

    // One request into the ALU
    typedef struct packed {
        logic [4:0]  op;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [15:0] wide_a;
        logic [15:0] wide_b;
        alu_flags_t  flags;
    } alu_req_t;

    // One result out of the ALU
    typedef struct packed {
        logic [7:0]  result8;
        logic [15:0] result16;
        logic        writes_acc;
        alu_flags_t  flags;
    } alu_res_t;

endpackage

FILE: hw/rtl/cafu_core.sv
// ============================================================================
// cafu_core
// Combinational datapath: byte ALU, rotates, DAA, 16-bit adds and flags.
// ============================================================================
module cafu_core
    import cafu_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  nib_sum;
    logic [7:0]  diff8;
    logic [4:0]  nib_sub;
    logic [8:0]  sub9;
    logic [7:0]  daa_corr;
    logic        daa_c;
    logic [7:0]  daa_r;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] off_ext;
    logic [4:0]  sp_nib;
    logic [8:0]  sp_byte;
    logic [7:0]  a;
    logic [7:0]  b;

    assign a = req.acc;
    assign b = req.operand;

    // Carry in for the with-carry forms
    assign cin = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? req.flags.c : 1'b0;

    // Adder and subtractor with nibble terms
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign diff8   = a - b - {7'd0, cin};
    assign nib_sub = {1'b0, b[3:0]} + {4'd0, cin};
    assign sub9    = {1'b0, b} + {8'd0, cin};

    // Decimal adjust
    always_comb
    begin
        daa_corr = 8'd0;
        daa_c    = req.flags.c;
        if (!req.flags.n)
        begin
            if (req.flags.h || (a[3:0] > DAA_LO_LIMIT))
                daa_corr = daa_corr | DAA_LO_CORR;
            if (req.flags.c || (a > DAA_HI_LIMIT))
            begin
                daa_corr = daa_corr | DAA_HI_CORR;
                daa_c    = 1'b1;
            end
            daa_r = a + daa_corr;
        end
        else
        begin
            if (req.flags.h)
                daa_corr = daa_corr | DAA_LO_CORR;
            if (req.flags.c)
                daa_corr = daa_corr | DAA_HI_CORR;
            daa_r = a - daa_corr;
        end
    end

    // 16-bit adds
    assign sum17   = {1'b0, req.wide_a} + {1'b0, req.wide_b};
    assign sum13   = {1'b0, req.wide_a[11:0]} + {1'b0, req.wide_b[11:0]};
    assign off_ext = {{8{b[7]}}, b};
    assign sp_nib  = {1'b0, req.wide_a[3:0]} + {1'b0, b[3:0]};
    assign sp_byte = {1'b0, req.wide_a[7:0]} + {1'b0, b};

    // Result and flag select
    always_comb
    begin
        res.result8    = 8'd0;
        res.result16   = 16'd0;
        res.writes_acc = 1'b0;
        res.flags      = req.flags;
        case (req.op)
            OP_ADD, OP_ADC:
            begin
                res.result8    = sum9[7:0];
                res.writes_acc = 1'b1;
                res.flags.z    = (sum9[7:0] == 8'd0);
                res.flags.n    = 1'b0;
                res.flags.h    = nib_sum[4];
                res.flags.c    = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                res.result8    = diff8;
                res.writes_acc = (req.op != OP_CP);
                res.flags.z    = (diff8 == 8'd0);
                res.flags.n    = 1'b1;
                res.flags.h    = ({1'b0, a[3:0]} < nib_sub);
                res.flags.c    = ({1'b0, a} < sub9);
            end
            OP_AND:
            begin
                res.result8    = a & b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR:
            begin
                res.result8    = a ^ b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR:
            begin
                res.result8    = a | b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC:
            begin
                res.result8    = a + 8'd1;
                res.writes_acc = 1'b1;
                res.flags.z    = (a == 8'hFF);
                res.flags.n    = 1'b0;
                res.flags.h    = (a[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                res.result8    = a - 8'd1;
                res.writes_acc = 1'b1;
                res.flags.z    = (a == 8'd1);
                res.flags.n    = 1'b1;
                res.flags.h    = (a[3:0] == 4'h0);
            end
            OP_RLCA:
            begin
                res.result8    = {a[6:0], a[7]};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRCA:
            begin
                res.result8    = {a[0], a[7:1]};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RLA:
            begin
                res.result8    = {a[6:0], req.flags.c};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_DAA:
            begin
                res.result8    = daa_r;
                res.writes_acc = 1'b1;
                res.flags.z    = (daa_r == 8'd0);
                res.flags.h    = 1'b0;
                res.flags.c    = daa_c;
            end
            OP_CPL:
            begin
                res.result8    = ~a;
                res.writes_acc = 1'b1;
                res.flags.n    = 1'b1;
                res.flags.h    = 1'b1;
            end
            OP_SCF:
            begin
                res.result8 = a;
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = 1'b1;
            end
            OP_CCF:
            begin
                res.result8 = a;
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = ~req.flags.c;
            end
            OP_ADD16:
            begin
                res.result16 = sum17[15:0];
                res.flags.n  = 1'b0;
                res.flags.h  = sum13[12];
                res.flags.c  = sum17[16];
            end
            OP_SPOFFSET:
            begin
                res.result16 = req.wide_a + off_ext;
                res.flags    = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_byte[8]};
            end
            // unused codes: zero results, flags pass through
            default:
            begin
                res.result8 = 8'd0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cpu_alu_flags_unit.sv
// ============================================================================
// cpu_alu_flags_unit
// 8-bit CPU ALU and flag unit with registered request and result stages.
// ============================================================================
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | op acc operand wide_a wide_b z/n/h/c_in
//  out     | out_valid/out_stall | result8 result16 writes_acc z/n/h/c_out
//
//  One request per clock when out is not stalled; each request passes the
//  request register, ALU logic and result register in that order.
//  Reset clears both stage valid bits; payload registers are not reset.
//  A stall on out holds the result; the request stage keeps filling until
//  both stages are occupied, then in_stall rises.
// ============================================================================
module cpu_alu_flags_unit
    import cafu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  op,
    input  logic [7:0]  acc,
    input  logic [7:0]  operand,
    input  logic [15:0] wide_a,
    input  logic [15:0] wide_b,
    input  logic        z_in,
    input  logic        n_in,
    input  logic        h_in,
    input  logic        c_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  result8,
    output logic [15:0] result16,
    output logic        writes_acc,
    output logic        z_out,
    output logic        n_out,
    output logic        h_out,
    output logic        c_out
);

    logic     req_valid_reg;
    logic     req_valid_next;
    alu_req_t req_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    alu_res_t res_reg;
    alu_res_t core_res;
    logic     res_load;
    logic     req_load;

    // Stage advance
    assign res_load = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !res_load;
    assign req_load = in_valid && !in_stall;

    assign req_valid_next = req_load || (req_valid_reg && !res_load);
    assign res_valid_next = res_load || (res_valid_reg && out_stall);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Request register
    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            req_reg <= '{op: op, acc: acc, operand: operand, wide_a: wide_a,
                         wide_b: wide_b,
                         flags: '{z: z_in, n: n_in, h: h_in, c: c_in}};
        end
    end

    // ALU datapath
    cafu_core u_core (
        .req (req_reg),
        .res (core_res)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid  = res_valid_reg;
    assign result8    = res_reg.result8;
    assign result16   = res_reg.result16;
    assign writes_acc = res_reg.writes_acc;
    assign z_out      = res_reg.flags.z;
    assign n_out      = res_reg.flags.n;
    assign h_out      = res_reg.flags.h;
    assign c_out      = res_reg.flags.c;

endmodule

FILE: bench/tb_cpu_alu_flags_unit.sv
// ============================================================================
// tb_cpu_alu_flags_unit
// Self-checking bench for the ALU and flag unit: a directed table of corner
// requests, then random requests, with random idle on both channels and a
// local predictor that computes every expected result not typed into the table.
// ============================================================================
module tb_cpu_alu_flags_unit
    import cafu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes outside the defined set
    localparam logic [4:0] OP_UNUSED_LOW = 5'd19;
    localparam logic [4:0] OP_UNUSED_TOP = 5'd31;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // One row of the directed table; known rows carry a typed-in result
    typedef struct {
        alu_req_t req;
        bit       known;
        alu_res_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [4:0]  op;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [15:0] wide_a;
    logic [15:0] wide_b;
    logic        z_in;
    logic        n_in;
    logic        h_in;
    logic        c_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  result8;
    logic [15:0] result16;
    logic        writes_acc;
    logic        z_out;
    logic        n_out;
    logic        h_out;
    logic        c_out;

    alu_res_t    pending_results[$];
    stim_row_t   corner_table[$];
    int          mismatch_count;
    int          cycle_count;
    bit          idle_off;

    cpu_alu_flags_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .acc        (acc),
        .operand    (operand),
        .wide_a     (wide_a),
        .wide_b     (wide_b),
        .z_in       (z_in),
        .n_in       (n_in),
        .h_in       (h_in),
        .c_in       (c_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result8    (result8),
        .result16   (result16),
        .writes_acc (writes_acc),
        .z_out      (z_out),
        .n_out      (n_out),
        .h_out      (h_out),
        .c_out      (c_out)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Expected ALU result and flags for one request
    function automatic alu_res_t alu_predict(alu_req_t r);
        alu_res_t   res;
        logic [7:0] a;
        logic [7:0] b;
        logic       cin;
        logic [8:0] sum9;
        logic [4:0] nib;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [7:0] corr;
        a   = r.acc;
        b   = r.operand;
        res = '0;
        res.flags = r.flags;
        case (r.op)
            OP_ADD, OP_ADC:
            begin
                cin  = (r.op == OP_ADC) ? r.flags.c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                res.result8    = sum9[7:0];
                res.writes_acc = 1'b1;
                res.flags.z    = (sum9[7:0] == 8'd0);
                res.flags.n    = 1'b0;
                res.flags.h    = nib[4];
                res.flags.c    = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                cin = (r.op == OP_SBC) ? r.flags.c : 1'b0;
                res.result8    = a - b - {7'd0, cin};
                res.writes_acc = (r.op != OP_CP);
                res.flags.z    = (res.result8 == 8'd0);
                res.flags.n    = 1'b1;
                // borrow out of the low nibble and out of the byte
                res.flags.h    = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cin});
                res.flags.c    = {1'b0, a} < ({1'b0, b} + {8'd0, cin});
            end
            OP_AND:
            begin
                res.result8    = a & b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: (res.result8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_XOR:
            begin
                res.result8    = a ^ b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: (res.result8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_OR:
            begin
                res.result8    = a | b;
                res.writes_acc = 1'b1;
                res.flags      = '{z: (res.result8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_INC:
            begin
                res.result8    = a + 8'd1;
                res.writes_acc = 1'b1;
                res.flags.z    = (res.result8 == 8'd0);
                res.flags.n    = 1'b0;
                res.flags.h    = (a[3:0] == 4'hF);
            end
            OP_DEC:
            begin
                res.result8    = a - 8'd1;
                res.writes_acc = 1'b1;
                res.flags.z    = (res.result8 == 8'd0);
                res.flags.n    = 1'b1;
                res.flags.h    = (a[3:0] == 4'h0);
            end
            // rotates always clear Z
            OP_RLCA:
            begin
                res.result8    = {a[6:0], a[7]};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            OP_RRCA:
            begin
                res.result8    = {a[0], a[7:1]};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            OP_RLA:
            begin
                res.result8    = {a[6:0], r.flags.c};
                res.writes_acc = 1'b1;
                res.flags      = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            // decimal adjust after add or after subtract
            OP_DAA:
            begin
                corr = 8'd0;
                if (!r.flags.n)
                begin
                    if (r.flags.h || (a[3:0] > DAA_LO_LIMIT))
                        corr = corr | DAA_LO_CORR;
                    if (r.flags.c || (a > DAA_HI_LIMIT))
                    begin
                        corr        = corr | DAA_HI_CORR;
                        res.flags.c = 1'b1;
                    end
                    res.result8 = a + corr;
                end
                else
                begin
                    if (r.flags.h)
                        corr = corr | DAA_LO_CORR;
                    if (r.flags.c)
                        corr = corr | DAA_HI_CORR;
                    res.result8 = a - corr;
                end
                res.writes_acc = 1'b1;
                res.flags.z    = (res.result8 == 8'd0);
                res.flags.h    = 1'b0;
            end
            OP_CPL:
            begin
                res.result8    = ~a;
                res.writes_acc = 1'b1;
                res.flags.n    = 1'b1;
                res.flags.h    = 1'b1;
            end
            OP_SCF:
            begin
                res.result8 = a;
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = 1'b1;
            end
            OP_CCF:
            begin
                res.result8 = a;
                res.flags.n = 1'b0;
                res.flags.h = 1'b0;
                res.flags.c = ~r.flags.c;
            end
            OP_ADD16:
            begin
                sum17 = {1'b0, r.wide_a} + {1'b0, r.wide_b};
                sum13 = {1'b0, r.wide_a[11:0]} + {1'b0, r.wide_b[11:0]};
                res.result16 = sum17[15:0];
                res.flags.n  = 1'b0;
                res.flags.h  = sum13[12];
                res.flags.c  = sum17[16];
            end
            // SP plus signed byte; H and C from unsigned low sums
            OP_SPOFFSET:
            begin
                sum9 = {1'b0, r.wide_a[7:0]} + {1'b0, b};
                nib  = {1'b0, r.wide_a[3:0]} + {1'b0, b[3:0]};
                res.result16 = r.wide_a + {{8{b[7]}}, b};
                res.flags    = '{z: 1'b0, n: 1'b0, h: nib[4], c: sum9[8]};
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic alu_req_t mk_req(logic [4:0] o, logic [7:0] a, logic [7:0] b,
                                        logic [15:0] wa, logic [15:0] wb,
                                        logic [3:0] flg = 4'd0);
        alu_req_t r;
        r.op      = o;
        r.acc     = a;
        r.operand = b;
        r.wide_a  = wa;
        r.wide_b  = wb;
        r.flags   = alu_flags_t'(flg);
        return r;
    endfunction

    function automatic stim_row_t mk_row(alu_req_t r, bit known, logic [7:0] r8 = 8'd0,
                                         logic [15:0] r16 = 16'd0, logic wr = 1'b0,
                                         logic [3:0] flg = 4'd0);
        stim_row_t row;
        row.req   = r;
        row.known = known;
        row.res.result8    = r8;
        row.res.result16   = r16;
        row.res.writes_acc = wr;
        row.res.flags      = alu_flags_t'(flg);
        return row;
    endfunction

    function automatic int draw_idle();
        return idle_off ? 0 : $urandom_range(0, 19);
    endfunction

    // Byte biased toward nibble and sign boundaries
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[8];
        corners = '{8'h00, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    // Drive one request; optionally hold off until all results are back
    task automatic send_request(alu_req_t r, alu_res_t exp, int gap, bit drain);
        if (gap > 0 || drain)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            while (drain && pending_results.size() != 0)
                @(negedge clk);
        end
        op       <= r.op;
        acc      <= r.acc;
        operand  <= r.operand;
        wide_a   <= r.wide_a;
        wide_b   <= r.wide_b;
        z_in     <= r.flags.z;
        n_in     <= r.flags.n;
        h_in     <= r.flags.h;
        c_in     <= r.flags.c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(exp);
        @(negedge clk);
    endtask

    // Result side: random stall, then compare each result with the oldest expected one
    initial
    begin : result_side
        alu_res_t exp;
        int       hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = draw_idle();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: result8=%h result16=%h",
                       result8, result16);
                mismatch_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                if (result8 !== exp.result8)
                begin
                    $error("result8 expected %h actual %h", exp.result8, result8);
                    mismatch_count++;
                end
                if (result16 !== exp.result16)
                begin
                    $error("result16 expected %h actual %h", exp.result16, result16);
                    mismatch_count++;
                end
                if (writes_acc !== exp.writes_acc)
                begin
                    $error("writes_acc expected %b actual %b", exp.writes_acc, writes_acc);
                    mismatch_count++;
                end
                if (z_out !== exp.flags.z)
                begin
                    $error("z_out expected %b actual %b", exp.flags.z, z_out);
                    mismatch_count++;
                end
                if (n_out !== exp.flags.n)
                begin
                    $error("n_out expected %b actual %b", exp.flags.n, n_out);
                    mismatch_count++;
                end
                if (h_out !== exp.flags.h)
                begin
                    $error("h_out expected %b actual %b", exp.flags.h, h_out);
                    mismatch_count++;
                end
                if (c_out !== exp.flags.c)
                begin
                    $error("c_out expected %b actual %b", exp.flags.c, c_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Request side: reset, directed table, random phases, drain
    initial
    begin : request_side
        alu_req_t  r;
        stim_row_t row;
        int        pick;
        mismatch_count = 0;
        idle_off = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = '0;
        acc      = '0;
        operand  = '0;
        wide_a   = '0;
        wide_b   = '0;
        z_in     = 1'b0;
        n_in     = 1'b0;
        h_in     = 1'b0;
        c_in     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners; flags written as {z,n,h,c}
        corner_table.push_back(mk_row(mk_req(OP_ADD, 8'hFF, 8'h01, 16'h0, 16'h0, 4'b0000),
                                      1'b1, 8'h00, 16'h0, 1'b1, 4'b1011));
        corner_table.push_back(mk_row(mk_req(OP_ADD, 8'hFF, 8'hFF, 16'h0, 16'h0, 4'b0000),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_ADC, 8'h0F, 8'h00, 16'h0, 16'h0, 4'b0001),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_SUB, 8'h00, 8'h01, 16'h0, 16'h0, 4'b0000),
                                      1'b1, 8'hFF, 16'h0, 1'b1, 4'b0111));
        // half-borrow with carry in pulling the low nibble negative
        corner_table.push_back(mk_row(mk_req(OP_SBC, 8'h10, 8'h00, 16'h0, 16'h0, 4'b0001),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_SBC, 8'h00, 8'hFF, 16'h0, 16'h0, 4'b0001),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_AND, 8'hFF, 8'hFF, 16'h0, 16'h0, 4'b1101),
                                      1'b1, 8'hFF, 16'h0, 1'b1, 4'b0010));
        corner_table.push_back(mk_row(mk_req(OP_XOR, 8'hAA, 8'hAA, 16'h0, 16'h0, 4'b0111),
                                      1'b1, 8'h00, 16'h0, 1'b1, 4'b1000));
        corner_table.push_back(mk_row(mk_req(OP_OR, 8'h00, 8'h00, 16'h0, 16'h0, 4'b0111),
                                      1'b1, 8'h00, 16'h0, 1'b1, 4'b1000));
        // compare leaves the accumulator alone
        corner_table.push_back(mk_row(mk_req(OP_CP, 8'h42, 8'h42, 16'h0, 16'h0, 4'b0000),
                                      1'b1, 8'h00, 16'h0, 1'b0, 4'b1100));
        corner_table.push_back(mk_row(mk_req(OP_INC, 8'hFF, 8'h00, 16'h0, 16'h0, 4'b0000),
                                      1'b1, 8'h00, 16'h0, 1'b1, 4'b1010));
        corner_table.push_back(mk_row(mk_req(OP_DEC, 8'h00, 8'h00, 16'h0, 16'h0, 4'b0001),
                                      1'b1, 8'hFF, 16'h0, 1'b1, 4'b0111));
        // rotates clear an incoming Z
        corner_table.push_back(mk_row(mk_req(OP_RLCA, 8'h80, 8'h00, 16'h0, 16'h0, 4'b1000),
                                      1'b1, 8'h01, 16'h0, 1'b1, 4'b0001));
        corner_table.push_back(mk_row(mk_req(OP_RRCA, 8'h01, 8'h00, 16'h0, 16'h0, 4'b1000),
                                      1'b1, 8'h80, 16'h0, 1'b1, 4'b0001));
        corner_table.push_back(mk_row(mk_req(OP_RLA, 8'h80, 8'h00, 16'h0, 16'h0, 4'b1001),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_DAA, 8'h9A, 8'h00, 16'h0, 16'h0, 4'b0000),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_DAA, 8'h00, 8'h00, 16'h0, 16'h0, 4'b0111),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_CPL, 8'h00, 8'h00, 16'h0, 16'h0, 4'b1000),
                                      1'b1, 8'hFF, 16'h0, 1'b1, 4'b1110));
        corner_table.push_back(mk_row(mk_req(OP_SCF, 8'h5A, 8'h00, 16'h0, 16'h0, 4'b0110),
                                      1'b1, 8'h5A, 16'h0, 1'b0, 4'b0001));
        corner_table.push_back(mk_row(mk_req(OP_CCF, 8'hA5, 8'h00, 16'h0, 16'h0, 4'b1111),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_ADD16, 8'h33, 8'h44, 16'hFFFF, 16'h0001,
                                             4'b1000),
                                      1'b1, 8'h00, 16'h0000, 1'b0, 4'b1011));
        corner_table.push_back(mk_row(mk_req(OP_ADD16, 8'h00, 8'h00, 16'h0800, 16'h0800,
                                             4'b0100),
                                      1'b0));
        // negative offset: sum sign-extends, H and C use the raw byte
        corner_table.push_back(mk_row(mk_req(OP_SPOFFSET, 8'h00, 8'h80, 16'h00FF, 16'h0,
                                             4'b1111),
                                      1'b0));
        corner_table.push_back(mk_row(mk_req(OP_SPOFFSET, 8'h00, 8'h01, 16'hFFFF, 16'h0,
                                             4'b0000),
                                      1'b0));
        // undefined ops pass the flags and zero everything else
        corner_table.push_back(mk_row(mk_req(OP_UNUSED_TOP, 8'hFF, 8'hFF, 16'hFFFF,
                                             16'hFFFF, 4'b1111),
                                      1'b1, 8'h00, 16'h0000, 1'b0, 4'b1111));
        corner_table.push_back(mk_row(mk_req(OP_UNUSED_LOW, 8'h12, 8'h34, 16'h5678,
                                             16'h9ABC, 4'b0101),
                                      1'b0));

        foreach (corner_table[i])
        begin
            row = corner_table[i];
            send_request(row.req, row.known ? row.res : alu_predict(row.req),
                         draw_idle(), 1'b0);
        end

        // Random phases: first with no idling, then with random idle on both sides
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_off = (phase == 0);
            for (int k = 0; k < RANDOM_ITEMS / 4; k++)
            begin
                pick = $urandom_range(0, 99);
                r.op      = (pick < 94) ? 5'($urandom_range(0, 18))
                                        : 5'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP));
                r.acc     = pick_byte();
                r.operand = pick_byte();
                r.wide_a  = 16'($urandom);
                r.wide_b  = 16'($urandom);
                r.flags   = alu_flags_t'(4'($urandom));
                send_request(r, alu_predict(r), draw_idle(), (phase == 2 && k == 50));
            end
        end
        in_valid <= 1'b0;

        // Wait for outstanding results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cafu_pkg.sv
hw/rtl/cafu_core.sv
hw/rtl/cpu_alu_flags_unit.sv
bench/tb_cpu_alu_flags_unit.sv
